// ===== hdl/sbrc_pkg.sv =====
// Package for the sixteen-bit register CPU step block.
// Holds word widths, memory sizes, opcodes, request codes, sequencer states and the
// structs that pass between the top level, the sequencer and the two memories.
package sbrc_pkg;

	localparam int WORD_W    = 16;
	localparam int MEM_WORDS = 65536;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int REG_COUNT = 16;
	localparam int RF_AW     = $clog2(REG_COUNT);

	localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_WORDS - 1);

	// Jump condition bits of the instruction word.
	localparam logic [WORD_W-1:0] COND_NZ = 16'b0000100000000000;
	localparam logic [WORD_W-1:0] COND_EQ = 16'b0000010000000000;
	localparam logic [WORD_W-1:0] COND_GT = 16'b0000001000000000;
	localparam logic [WORD_W-1:0] COND_LT = 16'b0000000100000000;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_EXEC  = 2'd2
	} req_kind_t;

	typedef enum logic [3:0] {
		OP_JMP = 4'd0,
		OP_LDI = 4'd1,
		OP_LDM = 4'd2,
		OP_STM = 4'd3,
		OP_LDP = 4'd4,
		OP_STP = 4'd5,
		OP_MOV = 4'd6,
		OP_ADD = 4'd7,
		OP_AND = 4'd8,
		OP_IOR = 4'd9,
		OP_XOR = 4'd10,
		OP_NOT = 4'd11,
		OP_SHL = 4'd12,
		OP_SHR = 4'd13,
		OP_INC = 4'd14,
		OP_DEC = 4'd15
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_OPR,
		S_WB,
		S_FETCH
	} seq_state_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [WORD_W-1:0] mem_addr;
		logic [WORD_W-1:0] mem_data;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [WORD_W-1:0] program_counter;
		logic              halted;
	} rsp_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [MEM_AW-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic              rd_en;
		logic [RF_AW-1:0]  ra_addr;
		logic [RF_AW-1:0]  rb_addr;
		logic              we;
		logic [RF_AW-1:0]  wa;
		logic [WORD_W-1:0] wd;
	} rf_req_t;

	// From the top level to the sequencer.
	typedef struct packed {
		logic req_v;
		req_t req;
		logic out_free;
	} feed_t;

	// From the sequencer to the top level.
	typedef struct packed {
		logic take;
		logic done;
		rsp_t rsp;
	} ack_t;

endpackage

// ===== hdl/sbrc_if.sv =====
// Request and response channel interfaces of the CPU step block.
// Depends on sbrc_pkg for the word width.
interface sbrc_req_if import sbrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [WORD_W-1:0] mem_addr;
	logic [WORD_W-1:0] mem_data;

	modport source(output valid, req_type, mem_addr, mem_data, input ready);
	modport sink(input valid, req_type, mem_addr, mem_data, output ready);
endinterface

interface sbrc_rsp_if import sbrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] read_data;
	logic [WORD_W-1:0] program_counter;
	logic              halted;

	modport source(output valid, read_data, program_counter, halted, input ready);
	modport sink(input valid, read_data, program_counter, halted, output ready);
endinterface

// ===== hdl/sbrc_mem.sv =====
// Main memory: single-port synchronous RAM with a registered read output.
// After reset it sweeps zeros through every word and reports busy meanwhile.
// Depends on sbrc_pkg.
module sbrc_mem import sbrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_req_t          req,
	output logic [WORD_W-1:0] rdata,
	output logic              busy
);

	logic [WORD_W-1:0] words_q [MEM_WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic              clr_q;
	logic [MEM_AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
			if (clr_cnt_q == MEM_LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			words_q[clr_cnt_q] <= '0;
		end else if (req.en && req.we) begin
			words_q[req.addr] <= req.wdata;
		end
	end

	// The read register holds its word until the next read.
	always_ff @(posedge clk) begin
		if (!clr_q && req.en && !req.we) begin
			rdata_q <= words_q[req.addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_q;

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !req.en)
		else $error("main memory accessed during the clearing pass");

	a_clear_ends_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> clr_cnt_q == '0)
		else $error("clearing pass ended before sweeping every word");

	a_clear_never_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_q |=> !clr_q)
		else $error("clearing pass restarted without reset");

endmodule

// ===== hdl/sbrc_rf.sv =====
// Register file: sixteen words, two registered read ports and one write port.
// A valid bit per entry makes never-written registers read as zero after reset.
// Depends on sbrc_pkg.
module sbrc_rf import sbrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rf_req_t           rf,
	output logic [WORD_W-1:0] ra_data,
	output logic [WORD_W-1:0] rb_data
);

	logic [WORD_W-1:0]    regs_q [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [WORD_W-1:0]    ra_q;
	logic [WORD_W-1:0]    rb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (rf.we) begin
			vld_q[rf.wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf.we) begin
			regs_q[rf.wa] <= rf.wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rf.rd_en) begin
			ra_q <= vld_q[rf.ra_addr] ? regs_q[rf.ra_addr] : '0;
			rb_q <= vld_q[rf.rb_addr] ? regs_q[rf.rb_addr] : '0;
		end
	end

	assign ra_data = ra_q;
	assign rb_data = rb_q;

endmodule

// ===== hdl/sbrc_seq.sv =====
// Sequencer of the CPU step block: runs one request at a time against the
// main memory and the register file, keeps the program counter and a copy of
// the word at the program counter. Depends on sbrc_pkg.
module sbrc_seq import sbrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  feed_t             feed,
	output ack_t              ack,
	output mem_req_t          mem,
	input  logic [WORD_W-1:0] mem_rdata,
	output rf_req_t           rf,
	input  logic [WORD_W-1:0] ra_data,
	input  logic [WORD_W-1:0] rb_data
);

	seq_state_t state_q, state_d;

	logic [WORD_W-1:0] pc_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] npc_q;
	logic [WORD_W-1:0] res_q;
	logic              wr_q;
	logic              load_q;
	logic [RF_AW-1:0]  dst_q;

	op_t               op;
	logic [RF_AW-1:0]  f_d, f_a, f_b;
	logic [WORD_W-1:0] pc1, pc2;
	logic              jmp_take;
	logic [WORD_W-1:0] x_npc;
	logic [WORD_W-1:0] x_res;
	logic              x_wr;
	logic              x_load;
	logic              addr_hit;
	logic              cur_zero;

	assign op       = op_t'(cur_q[15:12]);
	assign f_d      = cur_q[11:8];
	assign f_a      = cur_q[7:4];
	assign f_b      = cur_q[3:0];
	assign pc1      = pc_q + WORD_W'(1);
	assign pc2      = pc_q + WORD_W'(2);
	assign cur_zero = (cur_q == '0);
	assign addr_hit = (feed.req.mem_addr[MEM_AW-1:0] == pc_q[MEM_AW-1:0]);

	// Operands are valid in S_OPR: W from the memory, R[A] and R[B] or R[D]
	// from the register file.
	always_comb begin
		jmp_take = (((cur_q & COND_NZ) != '0) && (ra_data != '0))
			|| (((cur_q & COND_EQ) != '0) && (ra_data == rb_data))
			|| (((cur_q & COND_GT) != '0) && (ra_data > rb_data))
			|| (((cur_q & COND_LT) != '0) && (ra_data < rb_data));
		x_npc  = pc1;
		x_res  = '0;
		x_wr   = 1'b0;
		x_load = 1'b0;
		case (op)
			OP_JMP: begin
				x_npc = jmp_take ? mem_rdata : pc2;
			end
			OP_LDI: begin
				x_npc = pc2;
				x_res = mem_rdata;
				x_wr  = 1'b1;
			end
			OP_LDM: begin
				x_npc  = pc2;
				x_wr   = 1'b1;
				x_load = 1'b1;
			end
			OP_STM: begin
				x_npc = pc2;
			end
			OP_LDP: begin
				x_wr   = 1'b1;
				x_load = 1'b1;
			end
			OP_STP: begin
				x_wr = 1'b0;
			end
			OP_MOV: begin
				x_res = ra_data;
				x_wr  = 1'b1;
			end
			OP_ADD: begin
				x_res = ra_data + rb_data;
				x_wr  = 1'b1;
			end
			OP_AND: begin
				x_res = ra_data & rb_data;
				x_wr  = 1'b1;
			end
			OP_IOR: begin
				x_res = ra_data | rb_data;
				x_wr  = 1'b1;
			end
			OP_XOR: begin
				x_res = ra_data ^ rb_data;
				x_wr  = 1'b1;
			end
			OP_NOT: begin
				x_res = ~ra_data;
				x_wr  = 1'b1;
			end
			OP_SHL: begin
				x_res = {ra_data[WORD_W-2:0], 1'b0};
				x_wr  = 1'b1;
			end
			OP_SHR: begin
				x_res = {1'b0, ra_data[WORD_W-1:1]};
				x_wr  = 1'b1;
			end
			OP_INC: begin
				x_res = ra_data + WORD_W'(1);
				x_wr  = 1'b1;
			end
			default: begin
				x_res = ra_data - WORD_W'(1);
				x_wr  = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (feed.req_v) begin
					if (feed.req.req_type == REQ_READ) begin
						state_d = S_RD;
					end else if (feed.req.req_type == REQ_EXEC && !cur_zero) begin
						state_d = S_OPR;
					end
				end
			end
			S_RD: begin
				if (feed.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_OPR: begin
				state_d = S_WB;
			end
			S_WB: begin
				state_d = S_FETCH;
			end
			S_FETCH: begin
				if (feed.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ack                     = '0;
		ack.rsp.program_counter = pc_q;
		ack.rsp.halted          = cur_zero;
		mem                     = '0;
		rf                      = '0;
		rf.ra_addr              = f_a;
		rf.rb_addr              = (op == OP_STP) ? f_d : f_b;
		rf.wa                   = dst_q;
		rf.wd                   = load_q ? mem_rdata : res_q;
		case (state_q)
			S_IDLE: begin
				if (feed.req_v) begin
					case (feed.req.req_type)
						REQ_WRITE: begin
							if (feed.out_free) begin
								ack.take       = 1'b1;
								ack.done       = 1'b1;
								mem.en         = 1'b1;
								mem.we         = 1'b1;
								mem.addr       = feed.req.mem_addr[MEM_AW-1:0];
								mem.wdata      = feed.req.mem_data;
								ack.rsp.halted = addr_hit ? (feed.req.mem_data == '0)
									: cur_zero;
							end
						end
						REQ_READ: begin
							ack.take = 1'b1;
							mem.en   = 1'b1;
							mem.addr = feed.req.mem_addr[MEM_AW-1:0];
						end
						REQ_EXEC: begin
							if (cur_zero) begin
								ack.take = feed.out_free;
								ack.done = feed.out_free;
							end else begin
								ack.take = 1'b1;
								mem.en   = 1'b1;
								mem.addr = pc1[MEM_AW-1:0];
								rf.rd_en = 1'b1;
							end
						end
						default: begin
							ack.take = feed.out_free;
							ack.done = feed.out_free;
						end
					endcase
				end
			end
			S_RD: begin
				ack.done          = feed.out_free;
				ack.rsp.read_data = mem_rdata;
			end
			S_OPR: begin
				case (op)
					OP_LDM: begin
						mem.en   = 1'b1;
						mem.addr = mem_rdata[MEM_AW-1:0];
					end
					OP_STM: begin
						mem.en    = 1'b1;
						mem.we    = 1'b1;
						mem.addr  = mem_rdata[MEM_AW-1:0];
						mem.wdata = ra_data;
					end
					OP_LDP: begin
						mem.en   = 1'b1;
						mem.addr = ra_data[MEM_AW-1:0];
					end
					OP_STP: begin
						mem.en    = 1'b1;
						mem.we    = 1'b1;
						mem.addr  = ra_data[MEM_AW-1:0];
						mem.wdata = rb_data;
					end
					default: begin
						mem.en = 1'b0;
					end
				endcase
			end
			S_WB: begin
				rf.we    = wr_q;
				mem.en   = 1'b1;
				mem.addr = npc_q[MEM_AW-1:0];
			end
			S_FETCH: begin
				ack.done       = feed.out_free;
				ack.rsp.halted = (mem_rdata == '0);
			end
			default: begin
				ack.done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			cur_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_WB) begin
				pc_q <= npc_q;
			end
			// Keep the copy of the word at the program counter coherent.
			if (state_q == S_IDLE && ack.done && feed.req.req_type == REQ_WRITE
				&& addr_hit) begin
				cur_q <= feed.req.mem_data;
			end else if (state_q == S_FETCH && feed.out_free) begin
				cur_q <= mem_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OPR) begin
			npc_q  <= x_npc;
			res_q  <= x_res;
			wr_q   <= x_wr;
			load_q <= x_load;
			dst_q  <= f_d;
		end
	end

	a_done_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ack.done |-> feed.out_free)
		else $error("result produced while the output register is full");

	a_take_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		ack.take |-> feed.req_v)
		else $error("request taken from an empty input buffer");

	a_rf_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(rf.we && rf.rd_en))
		else $error("register file written and read in the same cycle");

	a_pc_moves_in_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_WB) |=> $stable(pc_q))
		else $error("program counter changed outside writeback");

endmodule

// ===== hdl/sixteen_bit_register_cpu_step.sv =====
// Channel  Dir  Payload                                      Handshake
// req      in   req_type, mem_addr, mem_data                 valid/ready
// rsp      out  read_data, program_counter, halted           valid/ready
//
// A read runs through S_RD and an instruction through S_OPR, S_WB and S_FETCH:
// operand word, data access and fetch of the next word share the one memory port.
// After reset a clearing pass writes zeros to all MEM_WORDS (65536) words, one per
// cycle; req.ready stays low until it ends. One request waits in an input buffer
// while another is in work, and a finished response waits in the output register.
// Depends on sbrc_pkg, sbrc_if, sbrc_mem, sbrc_rf and sbrc_seq.
module sixteen_bit_register_cpu_step import sbrc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	sbrc_req_if.sink   req,
	sbrc_rsp_if.source rsp
);

	logic              ibuf_v_q;
	req_t              ibuf_q;
	logic              obuf_v_q;
	rsp_t              obuf_q;
	logic              mem_busy;
	feed_t             feed;
	ack_t              ack;
	mem_req_t          mem;
	logic [WORD_W-1:0] mem_rdata;
	rf_req_t           rf;
	logic [WORD_W-1:0] ra_data;
	logic [WORD_W-1:0] rb_data;

	assign req.ready     = !mem_busy && (!ibuf_v_q || ack.take);
	assign feed.req_v    = ibuf_v_q;
	assign feed.req      = ibuf_q;
	assign feed.out_free = !obuf_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibuf_v_q <= 1'b0;
			obuf_v_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				ibuf_v_q <= 1'b1;
			end else if (ack.take) begin
				ibuf_v_q <= 1'b0;
			end
			if (ack.done) begin
				obuf_v_q <= 1'b1;
			end else if (rsp.ready) begin
				obuf_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			ibuf_q.req_type <= req.req_type;
			ibuf_q.mem_addr <= req.mem_addr;
			ibuf_q.mem_data <= req.mem_data;
		end
		if (ack.done) begin
			obuf_q <= ack.rsp;
		end
	end

	assign rsp.valid           = obuf_v_q;
	assign rsp.read_data       = obuf_q.read_data;
	assign rsp.program_counter = obuf_q.program_counter;
	assign rsp.halted          = obuf_q.halted;

	sbrc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.ack       (ack),
		.mem       (mem),
		.mem_rdata (mem_rdata),
		.rf        (rf),
		.ra_data   (ra_data),
		.rb_data   (rb_data)
	);

	sbrc_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	sbrc_rf u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rf      (rf),
		.ra_data (ra_data),
		.rb_data (rb_data)
	);

endmodule

// ===== tb/cpu_step_check_pkg.sv =====
// Scoreboard for the sixteen-bit register CPU step block: an instruction-level
// predictor with its own memory, register file and program counter, and the responses it expects.
// Depends on sbrc_pkg for widths, opcodes, request codes and the response struct.
package cpu_step_check_pkg;
	import sbrc_pkg::*;

	// JMP, LDI, LDM and STM carry a second word after the instruction.
	function automatic bit has_operand_word(op_t op);
		return op == OP_JMP || op == OP_LDI || op == OP_LDM || op == OP_STM;
	endfunction

	class cpu_step_scoreboard;
		bit [WORD_W-1:0] mem_image [MEM_WORDS];
		bit [WORD_W-1:0] regs [REG_COUNT];
		bit [WORD_W-1:0] pc;
		rsp_t due_responses[$];
		int errors;

		function int slot(bit [WORD_W-1:0] addr);
			return int'(addr) % MEM_WORDS;
		endfunction

		function void execute_at_pc();
			bit [WORD_W-1:0] ins, w, ra, rb, next1, next2;
			bit [3:0] d, a, b;
			bit taken;
			op_t op;
			ins = mem_image[slot(pc)];
			if (ins == '0)
				return;
			op = op_t'(ins[15:12]);
			d = ins[11:8];
			a = ins[7:4];
			b = ins[3:0];
			ra = regs[a];
			rb = regs[b];
			next1 = pc + 16'd1;
			next2 = pc + 16'd2;
			w = mem_image[slot(next1)];
			// The conditions are tried in priority order, but any one that holds
			// leads to the same target, so an OR gives the same outcome.
			taken = op == OP_JMP && (((ins & COND_NZ) != 0 && ra != 0) ||
				((ins & COND_EQ) != 0 && ra == rb) ||
				((ins & COND_GT) != 0 && ra > rb) ||
				((ins & COND_LT) != 0 && ra < rb));
			case (op)
				OP_LDI: regs[d] = w;
				OP_LDM: regs[d] = mem_image[slot(w)];
				OP_STM: mem_image[slot(w)] = ra;
				OP_LDP: regs[d] = mem_image[slot(ra)];
				OP_STP: mem_image[slot(ra)] = regs[d];
				OP_MOV: regs[d] = ra;
				OP_ADD: regs[d] = ra + rb;
				OP_AND: regs[d] = ra & rb;
				OP_IOR: regs[d] = ra | rb;
				OP_XOR: regs[d] = ra ^ rb;
				OP_NOT: regs[d] = ~ra;
				OP_SHL: regs[d] = ra << 1;
				OP_SHR: regs[d] = ra >> 1;
				OP_INC: regs[d] = ra + 16'd1;
				OP_DEC: regs[d] = ra - 16'd1;
				default: ;
			endcase
			pc = taken ? w : (has_operand_word(op) ? next2 : next1);
		endfunction

		function void note_request(bit [1:0] kind, bit [WORD_W-1:0] addr,
				bit [WORD_W-1:0] data);
			rsp_t want;
			want = '0;
			if (kind == REQ_WRITE)
				mem_image[slot(addr)] = data;
			else if (kind == REQ_READ)
				want.read_data = mem_image[slot(addr)];
			else if (kind == REQ_EXEC)
				execute_at_pc();
			want.program_counter = pc;
			want.halted = mem_image[slot(pc)] == '0;
			due_responses.push_back(want);
		endfunction

		function void check_response(logic [WORD_W-1:0] read_data,
				logic [WORD_W-1:0] program_counter, logic halted);
			rsp_t want;
			if (due_responses.size() == 0) begin
				$error("response with no request pending: read_data %h program_counter %h halted %b",
					read_data, program_counter, halted);
				errors++;
				return;
			end
			want = due_responses.pop_front();
			if (read_data !== want.read_data) begin
				$error("read_data: expected %h, got %h", want.read_data, read_data);
				errors++;
			end
			if (program_counter !== want.program_counter) begin
				$error("program_counter: expected %h, got %h", want.program_counter,
					program_counter);
				errors++;
			end
			if (halted !== want.halted) begin
				$error("halted: expected %b, got %b", want.halted, halted);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== tb/sixteen_bit_register_cpu_step_test.sv =====
// Top-level testbench of the sixteen-bit register CPU step block: directed requests, then
// mostly well-formed instruction requests with random content, under three idling patterns.
// Depends on sbrc_pkg, sbrc_if, the block itself and cpu_step_check_pkg.
module sixteen_bit_register_cpu_step_test import sbrc_pkg::*, cpu_step_check_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_NONE = 2'd3;	// request type the block ignores
	localparam int ITEM_TARGET = 1450;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 262144;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [WORD_W-1:0] DATA_BASE = 16'h8000;

	logic clk = 1'b0;
	logic arst_n;
	int src_idle_pct;
	int sink_idle_pct;
	bit hold_off_pending;
	int items_sent;
	int quiet_cycles;
	cpu_step_scoreboard sb = new;

	sbrc_req_if req_ch();
	sbrc_rsp_if rsp_ch();

	sixteen_bit_register_cpu_step uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	function automatic logic [WORD_W-1:0] data_addr();
		return ($urandom_range(3) != 0) ? DATA_BASE + WORD_W'($urandom_range(31))
			: WORD_W'($urandom);
	endfunction

	task automatic enter_phase(int src_pct, int sink_pct);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		hold_off_pending = 1'b1;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic offer(logic [1:0] kind, logic [WORD_W-1:0] addr, logic [WORD_W-1:0] data);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.mem_addr <= addr;
		req_ch.mem_data <= data;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(kind, addr, data);
		if (kind != REQ_NONE)
			items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [WORD_W-1:0] encode(op_t op, logic [3:0] d, logic [3:0] a,
			logic [3:0] b);
		return {op, d, a, b};
	endfunction

	initial begin : stimulus
		int choice;
		int phase;
		int phase_len;
		int phase1_at;
		int phase2_at;
		logic [WORD_W-1:0] pc_at;
		logic [WORD_W-1:0] w;
		op_t op;
		logic [3:0] d, a, b;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_WRITE;
		req_ch.mem_addr = '0;
		req_ch.mem_data = '0;
		enter_phase(22, 58);
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Cleared memory, a halted execute and an ignored request type.
		offer(REQ_READ, 16'h0000, 16'h0000);
		offer(REQ_EXEC, 16'h0000, 16'h0000);
		offer(REQ_NONE, 16'hFFFF, 16'hFFFF);
		offer(REQ_WRITE, 16'hFFFF, encode(OP_LDI, 4'd4, 4'd0, 4'd0));
		offer(REQ_READ, 16'hFFFF, 16'h0000);
		offer(REQ_WRITE, 16'h0000, encode(OP_LDI, 4'd1, 4'd0, 4'd0));
		offer(REQ_WRITE, 16'h0001, 16'hFFFF);
		offer(REQ_EXEC, 16'h0000, 16'h0000);
		// Increment wraps to zero.
		offer(REQ_WRITE, 16'h0002, encode(OP_INC, 4'd2, 4'd1, 4'd0));
		offer(REQ_EXEC, 16'h0000, 16'h0000);
		// A jump with no condition bits falls through.
		offer(REQ_WRITE, 16'h0003, encode(OP_JMP, 4'd0, 4'd1, 4'd2));
		offer(REQ_WRITE, 16'h0004, 16'h1234);
		offer(REQ_EXEC, 16'h0000, 16'h0000);
		offer(REQ_WRITE, 16'h0005, encode(OP_JMP, COND_NZ[11:8], 4'd1, 4'd0));
		offer(REQ_WRITE, 16'h0006, 16'hFFFE);
		offer(REQ_EXEC, 16'h0000, 16'h0000);
		offer(REQ_WRITE, 16'hFFFE, encode(OP_DEC, 4'd3, 4'd2, 4'd0));
		offer(REQ_EXEC, 16'h0000, 16'h0000);
		// The operand word of the load at the last address comes from address zero.
		offer(REQ_EXEC, 16'h0000, 16'h0000);
		offer(REQ_EXEC, 16'h0000, 16'h0000);
		offer(REQ_EXEC, 16'h0000, 16'h0000);
		offer(REQ_WRITE, 16'h0003, 16'h0000);
		offer(REQ_EXEC, 16'h0000, 16'h0000);

		phase = 0;
		phase_len = (ITEM_TARGET - items_sent) / 3;
		phase1_at = items_sent + phase_len;
		phase2_at = phase1_at + phase_len;
		while (items_sent < ITEM_TARGET) begin
			if (phase == 0 && items_sent >= phase1_at) begin
				enter_phase(58, 22);
				phase = 1;
			end else if (phase == 1 && items_sent >= phase2_at) begin
				enter_phase(0, 0);
				phase = 2;
			end
			choice = $urandom_range(99);
			if (choice < 70) begin
				pc_at = sb.pc;
				op = op_t'($urandom_range(15));
				d = 4'($urandom);
				a = 4'($urandom);
				b = ($urandom_range(3) == 0) ? a : 4'($urandom);
				case (op)
					OP_JMP: w = ($urandom_range(1) != 0) ? pc_at + WORD_W'($urandom_range(8))
						: WORD_W'($urandom);
					OP_LDI: w = ($urandom_range(1) != 0) ? data_addr() : WORD_W'($urandom);
					default: w = data_addr();
				endcase
				// Now and then the word already at the program counter runs instead.
				if ($urandom_range(9) != 0) begin
					offer(REQ_WRITE, pc_at, encode(op, d, a, b));
					if (has_operand_word(op))
						offer(REQ_WRITE, pc_at + 16'd1, w);
				end
				offer(REQ_EXEC, WORD_W'($urandom), WORD_W'($urandom));
			end else if (choice < 80) begin
				offer(REQ_READ, ($urandom_range(1) != 0) ? data_addr() : sb.pc,
					WORD_W'($urandom));
			end else if (choice < 90) begin
				offer(REQ_WRITE, data_addr(), WORD_W'($urandom));
			end else if (choice < 95) begin
				offer(REQ_NONE, WORD_W'($urandom), WORD_W'($urandom));
			end else begin
				offer(REQ_EXEC, WORD_W'($urandom), WORD_W'($urandom));
			end
		end

		req_ch.valid <= 1'b0;
		while (sb.due_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Response side: random stalls, and a long hold-off at the start and at each change of idling pattern.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.read_data, rsp_ch.program_counter, rsp_ch.halted);
	end

	// The clearing pass after reset is the longest correct stretch without a handshake.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
